FILE: rtl/kwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types, codes and default sizes for the k-way sorted merge.
// ----------------------------------------------------------------------------
package kwm_pkg;

  // default sizes
  localparam int NUM_LISTS_DEF   = 8;
  localparam int LIST_DEPTH_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 3;
  localparam int STATUS_W = 2;
  localparam int LIU_W    = 4;
  localparam logic [LIU_W-1:0] LIU_RESET = 4'd8;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_GIVEN     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  // per-cell control strobes
  typedef struct packed {
    logic active;
    logic clear;
    logic append;
    logic take;
    logic head_load;
  } cell_ctrl_t;

  // flags of the search token moving down the row
  typedef struct packed {
    logic valid;
    logic found;
  } tok_flags_t;

endpackage
`default_nettype wire

FILE: rtl/k_way_sorted_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merges up to NUM_LISTS ascending lists held in one RAM into one ascending
// stream, using a row of list cells that a search token walks through.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------
//   in      | in_valid/in_stall  | kind, list_index, value
//   out     | out_valid/out_stall| status, merged_value, last
//   cfg     | cfg_write          | cfg_data (lists_in_use)
//
// Append, clear and ignored kinds give no result; a dropped append goes to
// S_REPLY. A pop walks S_SCAN, where the token crosses one cell per cycle,
// then S_LOAD if the chosen list has a next head in the RAM, then S_REPLY.
// Reset is synchronous; it empties all lists and sets lists_in_use to 8.
// Input is stalled while an item is in flight or its result waits for the
// output register; a stalled output holds its beat.
// ----------------------------------------------------------------------------
module k_way_sorted_merge
  import kwm_pkg::*;
#(
  parameter int NUM_LISTS   = NUM_LISTS_DEF,
  parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [LIU_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [KIND_W-1:0]      kind,
  input  wire logic [INDEX_W-1:0]     list_index,
  input  wire logic [VALUE_WIDTH-1:0] value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [STATUS_W-1:0]         status,
  output logic [VALUE_WIDTH-1:0]      merged_value,
  output logic                        last
);

  localparam int LW  = $clog2(LIST_DEPTH+1);
  localparam int IW  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int RW  = $clog2(NUM_LISTS*LIST_DEPTH+1);
  localparam int AW  = (NUM_LISTS*LIST_DEPTH > 1) ? $clog2(NUM_LISTS*LIST_DEPTH) : 1;
  localparam int NW  = $clog2(NUM_LISTS+1);
  localparam int CW0 = (NW > LIU_W) ? NW : LIU_W;
  localparam int CW  = (CW0 > INDEX_W) ? CW0 : INDEX_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;
  localparam logic [1:0] S_REPLY = 2'd3;

  logic [1:0]             state;
  logic [LIU_W-1:0]       lists_in_use;
  logic [CW-1:0]          n_eff;

  logic                   in_take;
  logic [IW-1:0]          app_idx;
  logic                   bad_index;
  logic                   full;
  logic                   append_ok;
  logic                   pop_start;
  logic                   clear_all;
  logic                   scan_done;
  logic                   take_hit;
  logic                   need_load;
  logic [IW-1:0]          best_idx;
  logic [IW-1:0]          load_idx;
  logic [LW-1:0]          rp_best;
  logic [LW-1:0]          len_best;
  logic [VALUE_WIDTH-1:0] head_data;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;

  logic [STATUS_W-1:0]    pend_status;
  logic [VALUE_WIDTH-1:0] pend_value;
  logic                   pend_last;

  cell_ctrl_t             cell_ctrl [0:NUM_LISTS-1];
  logic [LW-1:0]          cell_len  [0:NUM_LISTS-1];
  logic [LW-1:0]          cell_rp   [0:NUM_LISTS-1];
  tok_flags_t             tf        [0:NUM_LISTS];
  logic [VALUE_WIDTH-1:0] tv        [0:NUM_LISTS];
  logic [IW-1:0]          ti        [0:NUM_LISTS];
  logic [RW-1:0]          tr        [0:NUM_LISTS];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      lists_in_use <= LIU_RESET;
    end else if (cfg_write) begin
      lists_in_use <= cfg_data;
    end
  end

  assign n_eff = (CW'(lists_in_use) > CW'(NUM_LISTS)) ? CW'(NUM_LISTS) : CW'(lists_in_use);

  // input decode
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign app_idx   = IW'(list_index);
  assign bad_index = (CW'(list_index) >= n_eff);
  assign full      = (cell_len[app_idx] == LW'(LIST_DEPTH));
  assign append_ok = in_take && (kind == KIND_APPEND) && !bad_index && !full;
  assign pop_start = in_take && (kind == KIND_POP);
  assign clear_all = in_take && (kind == KIND_CLEAR);

  // end of the cell row
  assign best_idx  = ti[NUM_LISTS];
  assign rp_best   = cell_rp[best_idx];
  assign len_best  = cell_len[best_idx];
  assign scan_done = (state == S_SCAN) && tf[NUM_LISTS].valid;
  assign take_hit  = scan_done && tf[NUM_LISTS].found;
  assign need_load = take_hit && ((rp_best + LW'(1)) < len_best);

  assign head_data = (state == S_LOAD) ? ram_rdata : value;
  assign waddr     = AW'(app_idx) * AW'(LIST_DEPTH) + AW'(cell_len[app_idx]);
  assign raddr     = AW'(best_idx) * AW'(LIST_DEPTH) + AW'(rp_best) + AW'(1);

  // token injected at the head of the row
  assign tf[0].valid = pop_start;
  assign tf[0].found = 1'b0;
  assign tv[0]       = '0;
  assign ti[0]       = '0;
  assign tr[0]       = '0;

  // row of list cells
  for (genvar i = 0; i < NUM_LISTS; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].active    = (CW'(i) < n_eff);
      cell_ctrl[i].clear     = clear_all;
      cell_ctrl[i].append    = append_ok && (app_idx == IW'(i));
      cell_ctrl[i].take      = take_hit && (best_idx == IW'(i));
      cell_ctrl[i].head_load = (state == S_LOAD) && (load_idx == IW'(i));
    end

    kwm_cell #(
      .NUM_LISTS   (NUM_LISTS),
      .LIST_DEPTH  (LIST_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .CELL_ID     (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (cell_ctrl[i]),
      .head_data     (head_data),
      .len           (cell_len[i]),
      .rp            (cell_rp[i]),
      .tok_in_flags  (tf[i]),
      .tok_in_value  (tv[i]),
      .tok_in_idx    (ti[i]),
      .tok_in_rem    (tr[i]),
      .tok_out_flags (tf[i+1]),
      .tok_out_value (tv[i+1]),
      .tok_out_idx   (ti[i+1]),
      .tok_out_rem   (tr[i+1])
    );
  end

  // list storage
  kwm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (NUM_LISTS*LIST_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (append_ok),
    .waddr (waddr),
    .wdata (value),
    .re    (need_load),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (kind == KIND_POP) begin
              state <= S_SCAN;
            end else if ((kind == KIND_APPEND) && (bad_index || full)) begin
              state <= S_REPLY;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= need_load ? S_LOAD : S_REPLY;
          end
        end
        S_LOAD: begin
          state <= S_REPLY;
        end
        S_REPLY: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (in_take) begin
      pend_status <= bad_index ? ST_BAD_INDEX : ST_FULL;
      pend_value  <= '0;
      pend_last   <= 1'b0;
    end else if (scan_done) begin
      pend_status <= tf[NUM_LISTS].found ? ST_GIVEN : ST_EMPTY;
      pend_value  <= tf[NUM_LISTS].found ? tv[NUM_LISTS] : '0;
      pend_last   <= tf[NUM_LISTS].found && (tr[NUM_LISTS] == RW'(1));
    end
    if (scan_done) begin
      load_idx <= best_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_REPLY) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_REPLY) && (!out_valid || !out_stall)) begin
      status       <= pend_status;
      merged_value <= pend_value;
      last         <= pend_last;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kwm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kwm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_cell
// One list slot: length, read position and cached head value. Folds its head
// into the search token and hands the token to the next cell each cycle.
// ----------------------------------------------------------------------------
module kwm_cell
  import kwm_pkg::*;
#(
  parameter int NUM_LISTS   = NUM_LISTS_DEF,
  parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int CELL_ID     = 0
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire cell_ctrl_t                             ctrl,
  input  wire logic [VALUE_WIDTH-1:0]                 head_data,
  output logic      [$clog2(LIST_DEPTH+1)-1:0]        len,
  output logic      [$clog2(LIST_DEPTH+1)-1:0]        rp,
  input  wire tok_flags_t                             tok_in_flags,
  input  wire logic [VALUE_WIDTH-1:0]                 tok_in_value,
  input  wire logic [((NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1)-1:0] tok_in_idx,
  input  wire logic [$clog2(NUM_LISTS*LIST_DEPTH+1)-1:0] tok_in_rem,
  output tok_flags_t                                  tok_out_flags,
  output logic      [VALUE_WIDTH-1:0]                 tok_out_value,
  output logic      [((NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1)-1:0] tok_out_idx,
  output logic      [$clog2(NUM_LISTS*LIST_DEPTH+1)-1:0] tok_out_rem
);

  localparam int LW = $clog2(LIST_DEPTH+1);
  localparam int IW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int RW = $clog2(NUM_LISTS*LIST_DEPTH+1);

  logic [VALUE_WIDTH-1:0] head;
  logic                   has_head;
  logic                   better;

  assign has_head = ctrl.active && (rp < len);
  assign better   = has_head &&
                    (!tok_in_flags.found || ($signed(head) < $signed(tok_in_value)));

  // length and read position
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      len <= '0;
      rp  <= '0;
    end else begin
      if (ctrl.append) begin
        len <= len + LW'(1);
      end
      if (ctrl.take) begin
        rp <= rp + LW'(1);
      end
    end
  end

  // head cache: direct on append to a drained list, else from memory
  always_ff @(posedge clk) begin
    if ((ctrl.append && (rp == len)) || ctrl.head_load) begin
      head <= head_data;
    end
  end

  // token valid moves one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_flags <= '0;
    end else begin
      tok_out_flags.valid <= tok_in_flags.valid;
      tok_out_flags.found <= tok_in_flags.found || has_head;
    end
  end

  // token payload: running minimum and unread count
  always_ff @(posedge clk) begin
    tok_out_value <= better ? head : tok_in_value;
    tok_out_idx   <= better ? IW'(CELL_ID) : tok_in_idx;
    tok_out_rem   <= has_head ? (tok_in_rem + RW'(len - rp)) : tok_in_rem;
  end

endmodule
`default_nettype wire
